### hdl/tpcs_pkg.sv
// Package for the timed production cycle sequencer.
// Holds beat types, codes, controller/datapath command and status, divider sizes.
// No dependencies.
package tpcs_pkg;

  localparam int unsigned MS_PER_MIN     = 60000;
  localparam int unsigned MS_ROUND       = 59999;
  localparam int unsigned SAVE_PERIOD_MS = 60000;
  localparam logic [15:0] SAT_MAX        = 16'hFFFF;

  localparam int unsigned DIV_W     = 34;
  localparam int unsigned DIVR_W    = 16;
  localparam int unsigned DIV_RADIX = 2;
  localparam int unsigned DIV_STEPS = DIV_W / DIV_RADIX;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRODUCTION = 2'd0,
    CFG_SETTLING   = 2'd1,
    CFG_TRANSFER   = 2'd2,
    CFG_POLARITY   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REQ_UPDATE  = 2'd0,
    REQ_BEGIN   = 2'd1,
    REQ_RESTORE = 2'd2,
    REQ_FORCE   = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    PH_STANDBY  = 3'd0,
    PH_PRODUCE  = 3'd1,
    PH_SETTLE   = 3'd2,
    PH_TRANSFER = 3'd3,
    PH_WAIT     = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    DIV_MOD = 2'd0,
    DIV_REM = 2'd1,
    DIV_EL  = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] now_ms;
    logic        bottle_full;
    logic        tank_full;
    logic [2:0]  target_phase;
    logic        saved_polarity;
    logic [15:0] saved_elapsed_min;
    logic [31:0] saved_cycles;
  } req_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic        electrolysis_on;
    logic        fan_on;
    logic        polarity_reversed;
    logic        valve_open;
    logic [15:0] remaining_min;
    logic [15:0] elapsed_min;
    logic [31:0] cycles_done;
    logic        save_request;
  } rsp_t;

  typedef struct packed {
    logic     calc_span;
    logic     apply;
    logic     apply_mod;
    logic     calc_elap;
    logic     calc_rem;
    logic     div_start;
    div_sel_t div_sel;
    logic     store_rem;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic need_mod;
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage

### hdl/tpcs_div.sv
// Iterative restoring divider, two quotient bits per cycle.
// Shared by the cycle-count modulo and the minute conversions; uses tpcs_pkg.
module tpcs_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [tpcs_pkg::DIV_W-1:0]     dividend,
  input  logic [tpcs_pkg::DIVR_W-1:0]    divisor,
  output logic                           busy,
  output logic [tpcs_pkg::DIV_W-1:0]     quotient,
  output logic [tpcs_pkg::DIVR_W-1:0]    remainder
);

  logic [tpcs_pkg::DIV_W-1:0]     q;
  logic [tpcs_pkg::DIVR_W-1:0]    r;
  logic [tpcs_pkg::DIVR_W-1:0]    dv;
  logic [tpcs_pkg::DIV_CNT_W-1:0] cnt;
  logic                           run;

  logic [tpcs_pkg::DIV_W-1:0]     q_next;
  logic [tpcs_pkg::DIVR_W-1:0]    r_next;
  logic [tpcs_pkg::DIVR_W:0]      trial;

  always_comb begin
    q_next = q;
    r_next = r;
    trial  = '0;
    for (int i = 0; i < tpcs_pkg::DIV_RADIX; i++) begin
      trial  = {r_next, q_next[tpcs_pkg::DIV_W-1]};
      q_next = {q_next[tpcs_pkg::DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dv}) begin
        r_next    = tpcs_pkg::DIVR_W'(trial - {1'b0, dv});
        q_next[0] = 1'b1;
      end else begin
        r_next = trial[tpcs_pkg::DIVR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      q   <= dividend;
      r   <= '0;
      dv  <= divisor;
      cnt <= tpcs_pkg::DIV_CNT_W'(tpcs_pkg::DIV_STEPS - 1);
      run <= 1'b1;
    end else if (run) begin
      q <= q_next;
      r <= r_next;
      if (cnt == '0) begin
        run <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  assign busy      = run | start;
  assign quotient  = q;
  assign remainder = r;

endmodule

### hdl/tpcs_dp.sv
// Datapath: configuration, sequencer state, phase timing and output register.
// Uses tpcs_pkg and tpcs_div; driven by tpcs_ctrl commands.
module tpcs_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            take,
  input  tpcs_pkg::req_t                  req,
  input  logic                            cfg_we,
  input  logic [tpcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpcs_pkg::CFG_DAT_W-1:0]  cfg_data,
  input  tpcs_pkg::cmd_t                  cmd,
  output tpcs_pkg::sts_t                  sts,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output tpcs_pkg::rsp_t                  rsp
);

  logic [31:0] prod_ms;
  logic [31:0] settle_ms;
  logic [31:0] xfer_ms;
  logic [7:0]  pol_every;

  tpcs_pkg::phase_t cur_phase;
  tpcs_pkg::phase_t phase_next;
  logic [31:0] phase_start, start_next;
  logic [31:0] credited, credit_next;
  logic        polarity, pol_next;
  logic [31:0] cycle_count, cycles_next;
  logic        save_pending, pend_next;
  logic [31:0] last_save, last_next;
  logic        need_mod, need_mod_next;

  tpcs_pkg::req_t item;
  logic [31:0] span;
  logic [31:0] deadline;
  logic [31:0] credit_prod;
  logic [32:0] elap;
  logic [31:0] rem_ms;
  logic [15:0] rem_min;

  logic [31:0] d_cur;
  logic [31:0] d_tgt;
  logic [32:0] elap_now;
  logic        time_up;
  logic [31:0] clamp;
  logic [7:0]  every;
  logic        save_now;

  logic [tpcs_pkg::DIV_W-1:0]  div_dividend;
  logic [tpcs_pkg::DIVR_W-1:0] div_divisor;
  logic                        div_busy;
  logic [tpcs_pkg::DIV_W-1:0]  div_quo;
  logic [tpcs_pkg::DIVR_W-1:0] div_rem;

  function automatic logic [15:0] sat16(input logic [tpcs_pkg::DIV_W-1:0] v);
    logic [15:0] res;
    res = (|v[tpcs_pkg::DIV_W-1:16]) ? tpcs_pkg::SAT_MAX : v[15:0];
    return res;
  endfunction

  always_comb begin
    case (cur_phase)
      tpcs_pkg::PH_PRODUCE:  d_cur = prod_ms;
      tpcs_pkg::PH_SETTLE:   d_cur = settle_ms;
      tpcs_pkg::PH_TRANSFER: d_cur = xfer_ms;
      default:               d_cur = '0;
    endcase
    case (item.target_phase)
      3'(tpcs_pkg::PH_PRODUCE):  d_tgt = prod_ms;
      3'(tpcs_pkg::PH_SETTLE):   d_tgt = settle_ms;
      3'(tpcs_pkg::PH_TRANSFER): d_tgt = xfer_ms;
      default:                   d_tgt = '0;
    endcase
  end

  assign elap_now = {1'b0, span} + {1'b0, credited};
  assign time_up  = (d_cur == '0) || (elap_now >= {1'b0, d_cur});
  assign clamp    = (credit_prod > d_tgt) ? d_tgt : credit_prod;
  assign every    = (pol_every == '0) ? 8'd1 : pol_every;
  assign save_now = save_pending ||
                    ((d_cur != '0) &&
                     ((item.now_ms - last_save) >= 32'(tpcs_pkg::SAVE_PERIOD_MS)));

  always_comb begin
    phase_next    = cur_phase;
    start_next    = phase_start;
    credit_next   = credited;
    pol_next      = polarity;
    cycles_next   = cycle_count;
    pend_next     = save_pending;
    last_next     = last_save;
    need_mod_next = need_mod;
    if (cmd.apply) begin
      need_mod_next = 1'b0;
      case (item.req_type)
        tpcs_pkg::REQ_UPDATE: begin
          case (cur_phase)
            tpcs_pkg::PH_STANDBY: begin
              if (item.bottle_full) begin
                phase_next  = tpcs_pkg::PH_PRODUCE;
                start_next  = item.now_ms;
                credit_next = '0;
                pend_next   = 1'b1;
              end
            end
            tpcs_pkg::PH_PRODUCE: begin
              if (time_up) begin
                cycles_next   = cycle_count + 32'd1;
                need_mod_next = 1'b1;
                phase_next    = tpcs_pkg::PH_SETTLE;
                start_next    = deadline;
                credit_next   = '0;
                pend_next     = 1'b1;
              end
            end
            tpcs_pkg::PH_SETTLE: begin
              if (time_up) begin
                phase_next  = item.tank_full ? tpcs_pkg::PH_WAIT : tpcs_pkg::PH_TRANSFER;
                start_next  = deadline;
                credit_next = '0;
                pend_next   = 1'b1;
              end
            end
            tpcs_pkg::PH_WAIT: begin
              if (!item.tank_full) begin
                phase_next  = tpcs_pkg::PH_TRANSFER;
                start_next  = item.now_ms;
                credit_next = '0;
                pend_next   = 1'b1;
              end
            end
            tpcs_pkg::PH_TRANSFER: begin
              if (time_up) begin
                phase_next  = tpcs_pkg::PH_STANDBY;
                start_next  = deadline;
                credit_next = '0;
                pend_next   = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        tpcs_pkg::REQ_BEGIN: begin
          phase_next  = tpcs_pkg::PH_STANDBY;
          start_next  = item.now_ms;
          credit_next = '0;
          pend_next   = 1'b0;
        end
        tpcs_pkg::REQ_RESTORE: begin
          pol_next    = item.saved_polarity;
          cycles_next = item.saved_cycles;
          start_next  = item.now_ms;
          pend_next   = 1'b0;
          if (item.target_phase inside {3'(tpcs_pkg::PH_PRODUCE), 3'(tpcs_pkg::PH_SETTLE),
                                        3'(tpcs_pkg::PH_TRANSFER)}) begin
            phase_next  = tpcs_pkg::phase_t'(item.target_phase);
            credit_next = clamp;
          end else if (item.target_phase == 3'(tpcs_pkg::PH_WAIT)) begin
            phase_next  = tpcs_pkg::PH_WAIT;
            credit_next = '0;
          end else begin
            phase_next  = tpcs_pkg::PH_STANDBY;
            credit_next = '0;
          end
        end
        tpcs_pkg::REQ_FORCE: begin
          phase_next  = (item.target_phase <= 3'(tpcs_pkg::PH_WAIT)) ?
                        tpcs_pkg::phase_t'(item.target_phase) : tpcs_pkg::PH_STANDBY;
          start_next  = item.now_ms;
          credit_next = '0;
          pend_next   = 1'b1;
        end
        default: begin
        end
      endcase
    end
    if (cmd.apply_mod && (div_rem == '0)) begin
      pol_next = !polarity;
    end
    if (cmd.finish && save_now) begin
      pend_next = 1'b0;
      last_next = item.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_ms      <= '0;
      settle_ms    <= '0;
      xfer_ms      <= '0;
      pol_every    <= 8'd1;
      cur_phase    <= tpcs_pkg::PH_STANDBY;
      phase_start  <= '0;
      credited     <= '0;
      polarity     <= 1'b0;
      cycle_count  <= '0;
      save_pending <= 1'b0;
      last_save    <= '0;
      need_mod     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tpcs_pkg::CFG_PRODUCTION: prod_ms   <= cfg_data;
          tpcs_pkg::CFG_SETTLING:   settle_ms <= cfg_data;
          tpcs_pkg::CFG_TRANSFER:   xfer_ms   <= cfg_data;
          tpcs_pkg::CFG_POLARITY:   pol_every <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
      cur_phase    <= phase_next;
      phase_start  <= start_next;
      credited     <= credit_next;
      polarity     <= pol_next;
      cycle_count  <= cycles_next;
      save_pending <= pend_next;
      last_save    <= last_next;
      need_mod     <= need_mod_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= req;
    end
    if (cmd.calc_span) begin
      span        <= item.now_ms - phase_start;
      deadline    <= phase_start + d_cur - credited;
      credit_prod <= 32'(item.saved_elapsed_min) * 32'(tpcs_pkg::MS_PER_MIN);
    end
    if (cmd.calc_elap) begin
      elap <= elap_now;
    end
    if (cmd.calc_rem) begin
      rem_ms <= (elap >= {1'b0, d_cur}) ? '0 : 32'({1'b0, d_cur} - elap);
    end
    if (cmd.store_rem) begin
      rem_min <= sat16(div_quo);
    end
  end

  always_comb begin
    case (cmd.div_sel)
      tpcs_pkg::DIV_MOD: begin
        div_dividend = tpcs_pkg::DIV_W'(cycle_count);
        div_divisor  = tpcs_pkg::DIVR_W'(every);
      end
      tpcs_pkg::DIV_REM: begin
        div_dividend = tpcs_pkg::DIV_W'({1'b0, rem_ms} + 33'(tpcs_pkg::MS_ROUND));
        div_divisor  = tpcs_pkg::DIVR_W'(tpcs_pkg::MS_PER_MIN);
      end
      default: begin
        div_dividend = tpcs_pkg::DIV_W'(elap);
        div_divisor  = tpcs_pkg::DIVR_W'(tpcs_pkg::MS_PER_MIN);
      end
    endcase
  end

  tpcs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp.phase             <= cur_phase;
      rsp.electrolysis_on   <= (cur_phase == tpcs_pkg::PH_PRODUCE);
      rsp.fan_on            <= (cur_phase == tpcs_pkg::PH_PRODUCE);
      rsp.polarity_reversed <= polarity;
      rsp.valve_open        <= (cur_phase == tpcs_pkg::PH_TRANSFER);
      rsp.remaining_min     <= rem_min;
      rsp.elapsed_min       <= sat16(div_quo);
      rsp.cycles_done       <= cycle_count;
      rsp.save_request      <= save_now;
    end
  end

  assign sts.need_mod = need_mod;
  assign sts.div_busy = div_busy;
  assign sts.out_free = !rsp_valid || !rsp_stall;

endmodule

### hdl/tpcs_ctrl.sv
// Controller: steps one request beat through apply, modulo and minute conversions.
// Uses tpcs_pkg; commands tpcs_dp.
module tpcs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  tpcs_pkg::sts_t sts,
  output tpcs_pkg::cmd_t cmd,
  output logic           busy
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SPAN,
    S_APPLY,
    S_CHK,
    S_MODW,
    S_SPAN2,
    S_ELAP,
    S_REMC,
    S_REMW,
    S_ELW,
    S_FIN,
    S_DONE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cmd   <= '0;
      busy  <= 1'b0;
    end else begin
      cmd <= '0;
      case (state)
        S_IDLE: begin
          if (take) begin
            busy          <= 1'b1;
            cmd.calc_span <= 1'b1;
            state         <= S_SPAN;
          end
        end
        S_SPAN: begin
          cmd.apply <= 1'b1;
          state     <= S_APPLY;
        end
        S_APPLY: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (sts.need_mod) begin
            cmd.div_start <= 1'b1;
            cmd.div_sel   <= tpcs_pkg::DIV_MOD;
            state         <= S_MODW;
          end else begin
            cmd.calc_span <= 1'b1;
            state         <= S_SPAN2;
          end
        end
        S_MODW: begin
          if (!sts.div_busy) begin
            cmd.apply_mod <= 1'b1;
            cmd.calc_span <= 1'b1;
            state         <= S_SPAN2;
          end
        end
        S_SPAN2: begin
          cmd.calc_elap <= 1'b1;
          state         <= S_ELAP;
        end
        S_ELAP: begin
          cmd.calc_rem <= 1'b1;
          state        <= S_REMC;
        end
        S_REMC: begin
          cmd.div_start <= 1'b1;
          cmd.div_sel   <= tpcs_pkg::DIV_REM;
          state         <= S_REMW;
        end
        S_REMW: begin
          if (!sts.div_busy) begin
            cmd.store_rem <= 1'b1;
            cmd.div_start <= 1'b1;
            cmd.div_sel   <= tpcs_pkg::DIV_EL;
            state         <= S_ELW;
          end
        end
        S_ELW: begin
          if (!sts.div_busy) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (sts.out_free) begin
            cmd.finish <= 1'b1;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          busy  <= 1'b0;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/timed_production_cycle_sequencer_top.sv
// Top level of the timed production cycle sequencer.
// Joins tpcs_ctrl and tpcs_dp; beat types from tpcs_pkg.
//
//   channel  direction  handshake             payload
//   req      in         req_valid, req_stall  tpcs_pkg::req_t
//   rsp      out        rsp_valid, rsp_stall  tpcs_pkg::rsp_t
//   cfg      in         cfg_we                cfg_index, cfg_data
//
// One request beat at a time; the two-bit-per-cycle divider runs the polarity
// modulo, when a production phase completes, and the two minute conversions
// one after another.
// req_stall stays high from accept until the result is loaded into the output
// register; a stalled rsp holds the finished result and delays the next one.
// Synchronous reset restores phase state, config, control and rsp_valid, not payloads.
module timed_production_cycle_sequencer_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  tpcs_pkg::req_t                  req,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output tpcs_pkg::rsp_t                  rsp,
  input  logic                            cfg_we,
  input  logic [tpcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpcs_pkg::CFG_DAT_W-1:0]  cfg_data
);

  tpcs_pkg::cmd_t cmd;
  tpcs_pkg::sts_t sts;
  logic           take;

  assign take = req_valid && !req_stall;

  tpcs_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .sts  (sts),
    .cmd  (cmd),
    .busy (req_stall)
  );

  tpcs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

### tb/tb_timed_production_cycle_sequencer_top.sv
// Testbench for timed_production_cycle_sequencer_top: directed phase, restore and
// counter tests, then random traffic under several register settings.
// Depends on tpcs_pkg and the RTL only; a local predictor checks every result beat.
module tb_timed_production_cycle_sequencer_top;
  import tpcs_pkg::*;

  localparam logic [2:0] PH_UNUSED_LO = 3'd5;
  localparam logic [2:0] PH_UNUSED_HI = 3'd7;
  localparam int unsigned DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_PRODUCTION;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  timed_production_cycle_sequencer_top uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // sequencer model state and register copies
  logic [31:0] prod_ms, settle_ms, xfer_ms;
  logic [7:0]  flip_every;
  phase_t      cur_phase;
  logic [31:0] phase_start, phase_credit, cycle_cnt, last_save;
  logic        pol_flag, save_due;

  rsp_t pending_status[$];
  rsp_t want_rsp;
  int errors = 0;
  int sent_cnt = 0;
  int checked_cnt = 0;
  int settings_cnt = 0;
  bit calm = 1'b0;
  bit stall_armed = 1'b0;
  int stall_left = 0;
  logic [31:0] t_ms = 32'd1000;

  function automatic logic [31:0] dur_of(phase_t p);
    case (p)
      PH_PRODUCE:  return prod_ms;
      PH_SETTLE:   return settle_ms;
      PH_TRANSFER: return xfer_ms;
      default:     return 32'd0;
    endcase
  endfunction

  function automatic logic [63:0] elapsed_of(logic [31:0] now);
    return {32'd0, now - phase_start} + {32'd0, phase_credit};
  endfunction

  function automatic logic [63:0] remaining_of(logic [31:0] now);
    logic [63:0] d, e;
    d = {32'd0, dur_of(cur_phase)};
    e = elapsed_of(now);
    return (e >= d) ? 64'd0 : d - e;
  endfunction

  task automatic enter_phase(phase_t p, logic [31:0] start, logic [31:0] credit);
    cur_phase = p;
    phase_start = start;
    phase_credit = credit;
    save_due = 1'b1;
  endtask

  task automatic reset_model();
    prod_ms = '0;
    settle_ms = '0;
    xfer_ms = '0;
    flip_every = 8'd1;
    cur_phase = PH_STANDBY;
    phase_start = '0;
    phase_credit = '0;
    pol_flag = 1'b0;
    cycle_cnt = '0;
    save_due = 1'b0;
    last_save = '0;
  endtask

  task automatic advance_sequencer(input req_t r, output rsp_t o);
    logic [63:0] rem_min, el_min;
    logic [31:0] now, dl, credit, every;
    logic time_up, periodic;
    phase_t tgt;
    now = r.now_ms;
    tgt = (r.target_phase <= PH_WAIT) ? phase_t'(r.target_phase) : PH_STANDBY;
    case (req_type_t'(r.req_type))
      REQ_UPDATE: begin
        time_up = (dur_of(cur_phase) > 0) ? (remaining_of(now) == 0) : 1'b1;
        dl = phase_start + dur_of(cur_phase) - phase_credit;
        case (cur_phase)
          PH_STANDBY: if (r.bottle_full) enter_phase(PH_PRODUCE, now, 32'd0);
          PH_PRODUCE: if (time_up) begin
            cycle_cnt = cycle_cnt + 32'd1;
            every = (flip_every == 0) ? 32'd1 : {24'd0, flip_every};
            if (cycle_cnt % every == 0) pol_flag = !pol_flag;
            enter_phase(PH_SETTLE, dl, 32'd0);
          end
          PH_SETTLE: if (time_up) enter_phase(r.tank_full ? PH_WAIT : PH_TRANSFER, dl, 32'd0);
          PH_WAIT: if (!r.tank_full) enter_phase(PH_TRANSFER, now, 32'd0);
          PH_TRANSFER: if (time_up) enter_phase(PH_STANDBY, dl, 32'd0);
          default: ;
        endcase
      end
      REQ_BEGIN: begin
        enter_phase(PH_STANDBY, now, 32'd0);
        save_due = 1'b0;
      end
      REQ_RESTORE: begin
        pol_flag = r.saved_polarity;
        cycle_cnt = r.saved_cycles;
        if (tgt == PH_PRODUCE || tgt == PH_SETTLE || tgt == PH_TRANSFER) begin
          credit = {16'd0, r.saved_elapsed_min} * MS_PER_MIN;
          if (credit > dur_of(tgt)) credit = dur_of(tgt);
          enter_phase(tgt, now, credit);
        end else begin
          enter_phase(tgt, now, 32'd0);
        end
        save_due = 1'b0;
      end
      REQ_FORCE: enter_phase(tgt, now, 32'd0);
      default: ;
    endcase
    rem_min = (remaining_of(now) + MS_ROUND) / MS_PER_MIN;
    el_min = elapsed_of(now) / MS_PER_MIN;
    periodic = (dur_of(cur_phase) > 0) && ((now - last_save) >= SAVE_PERIOD_MS);
    o.save_request = save_due || periodic;
    if (o.save_request) begin
      save_due = 1'b0;
      last_save = now;
    end
    o.phase = cur_phase;
    o.electrolysis_on = (cur_phase == PH_PRODUCE);
    o.fan_on = (cur_phase == PH_PRODUCE);
    o.polarity_reversed = pol_flag;
    o.valve_open = (cur_phase == PH_TRANSFER);
    o.remaining_min = (rem_min > SAT_MAX) ? SAT_MAX : rem_min[15:0];
    o.elapsed_min = (el_min > SAT_MAX) ? SAT_MAX : el_min[15:0];
    o.cycles_done = cycle_cnt;
  endtask

  function automatic req_t mk_req(req_type_t k, logic [31:0] now, logic bottle, logic tank,
                                  logic [2:0] tgt, logic pol, logic [15:0] mins,
                                  logic [31:0] cyc);
    req_t r;
    r.req_type = k;
    r.now_ms = now;
    r.bottle_full = bottle;
    r.tank_full = tank;
    r.target_phase = tgt;
    r.saved_polarity = pol;
    r.saved_elapsed_min = mins;
    r.saved_cycles = cyc;
    return r;
  endfunction

  task automatic send_req(input req_t r);
    int gap;
    rsp_t want;
    gap = calm ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if ($urandom_range(0, 1) == 1) while (req_stall) @(negedge clk);
    repeat (gap) @(negedge clk);
    req = r;
    req_valid = 1'b1;
    do @(posedge clk); while (req_stall);
    advance_sequencer(r, want);
    pending_status.push_back(want);
    sent_cnt++;
    @(negedge clk);
    req_valid = 1'b0;
  endtask

  task automatic drain_results();
    while (pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_PRODUCTION: prod_ms = val;
      CFG_SETTLING:   settle_ms = val;
      CFG_TRANSFER:   xfer_ms = val;
      CFG_POLARITY:   flip_every = val[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [31:0] p, logic [31:0] s, logic [31:0] x,
                                logic [31:0] e);
    drain_results();
    write_reg(CFG_PRODUCTION, p);
    write_reg(CFG_SETTLING, s);
    write_reg(CFG_TRANSFER, x);
    write_reg(CFG_POLARITY, e);
    settings_cnt++;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // hold results at random, whether or not a beat is offered
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall = 1'b0;
    end else if (!rsp_valid) begin
      rsp_stall = !calm && ($urandom_range(0, 3) == 0);
    end else begin
      if (!stall_armed) begin
        stall_left = calm ? 0 : $urandom_range(0, 4);
        stall_armed = 1'b1;
      end
      if (stall_left > 0) begin
        rsp_stall = 1'b1;
        stall_left--;
      end else begin
        rsp_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_status.size() == 0) begin
        $display("%0t: result beat with none expected, expected none, actual %p", $time, rsp);
        errors++;
      end else begin
        want_rsp = pending_status.pop_front();
        check_field("phase", want_rsp.phase, rsp.phase);
        check_field("electrolysis_on", want_rsp.electrolysis_on, rsp.electrolysis_on);
        check_field("fan_on", want_rsp.fan_on, rsp.fan_on);
        check_field("polarity_reversed", want_rsp.polarity_reversed, rsp.polarity_reversed);
        check_field("valve_open", want_rsp.valve_open, rsp.valve_open);
        check_field("remaining_min", want_rsp.remaining_min, rsp.remaining_min);
        check_field("elapsed_min", want_rsp.elapsed_min, rsp.elapsed_min);
        check_field("cycles_done", want_rsp.cycles_done, rsp.cycles_done);
        check_field("save_request", want_rsp.save_request, rsp.save_request);
        checked_cnt++;
      end
      stall_armed = 1'b0;
    end
  end

  task automatic test_default_cycle();
    send_req(mk_req(REQ_UPDATE, 32'd1000, 1'b0, 1'b0, PH_STANDBY, 1'b0, 16'd0, 32'd0));
    send_req(mk_req(REQ_UPDATE, 32'd1010, 1'b1, 1'b0, PH_STANDBY, 1'b0, 16'd0, 32'd0));
    send_req(mk_req(REQ_UPDATE, 32'd1020, 1'b0, 1'b0, PH_STANDBY, 1'b0, 16'd0, 32'd0));
    send_req(mk_req(REQ_UPDATE, 32'd1030, 1'b0, 1'b1, PH_STANDBY, 1'b0, 16'd0, 32'd0));
    send_req(mk_req(REQ_UPDATE, 32'd90000, 1'b1, 1'b1, PH_STANDBY, 1'b0, 16'd0, 32'd0));
    send_req(mk_req(REQ_UPDATE, 32'd90010, 1'b0, 1'b0, PH_STANDBY, 1'b0, 16'd0, 32'd0));
    send_req(mk_req(REQ_UPDATE, 32'd90020, 1'b1, 1'b1, PH_STANDBY, 1'b0, 16'd0, 32'd0));
    send_req(mk_req(REQ_BEGIN, 32'hFFFF_FFFF, 1'b1, 1'b1, PH_UNUSED_HI, 1'b1, 16'hFFFF,
                    32'hFFFF_FFFF));
  endtask

  task automatic test_restore_and_force();
    apply_settings(32'hFFFF_FFFF, 32'd120000, 32'd1, 32'd0);
    send_req(mk_req(REQ_RESTORE, 32'hFFFF_0000, 1'b0, 1'b0, PH_PRODUCE, 1'b1, 16'hFFFF,
                    32'hFFFF_FFFF));
    send_req(mk_req(REQ_UPDATE, 32'h3B9A_0000, 1'b0, 1'b0, PH_STANDBY, 1'b0, 16'd0, 32'd0));
    send_req(mk_req(REQ_RESTORE, 32'h3B9B_0000, 1'b0, 1'b0, PH_SETTLE, 1'b0, 16'd5, 32'd7));
    send_req(mk_req(REQ_UPDATE, 32'h3B9B_0001, 1'b0, 1'b1, PH_STANDBY, 1'b0, 16'd0, 32'd0));
    send_req(mk_req(REQ_RESTORE, 32'h3B9C_0000, 1'b0, 1'b0, PH_TRANSFER, 1'b1, 16'd0,
                    32'd3));
    send_req(mk_req(REQ_RESTORE, 32'h3B9D_0000, 1'b0, 1'b0, PH_WAIT, 1'b0, 16'd9, 32'd4));
    send_req(mk_req(REQ_RESTORE, 32'h3B9E_0000, 1'b1, 1'b0, PH_STANDBY, 1'b1, 16'd2, 32'd5));
    send_req(mk_req(REQ_RESTORE, 32'h3B9F_0000, 1'b0, 1'b0, PH_UNUSED_LO, 1'b0, 16'd1,
                    32'd6));
    send_req(mk_req(REQ_FORCE, 32'h3BA0_0000, 1'b0, 1'b0, PH_UNUSED_HI, 1'b0, 16'd0, 32'd0));
    send_req(mk_req(REQ_FORCE, 32'h3BA1_0000, 1'b0, 1'b0, PH_WAIT, 1'b0, 16'd0, 32'd0));
    send_req(mk_req(REQ_FORCE, 32'h3BA2_0000, 1'b0, 1'b0, PH_TRANSFER, 1'b0, 16'd0, 32'd0));
    send_req(mk_req(REQ_FORCE, 32'h3BA3_0000, 1'b0, 1'b0, PH_PRODUCE, 1'b0, 16'd0, 32'd0));
  endtask

  task automatic test_cycle_counter_wrap();
    apply_settings(32'd60000, 32'd0, 32'd0, 32'd255);
    send_req(mk_req(REQ_RESTORE, 32'd5000, 1'b0, 1'b0, PH_PRODUCE, 1'b0, 16'd1,
                    32'hFFFF_FFFE));
    send_req(mk_req(REQ_UPDATE, 32'd5001, 1'b0, 1'b0, PH_STANDBY, 1'b0, 16'd0, 32'd0));
    send_req(mk_req(REQ_FORCE, 32'd6000, 1'b0, 1'b0, PH_PRODUCE, 1'b0, 16'd0, 32'd0));
    send_req(mk_req(REQ_UPDATE, 32'd65999, 1'b0, 1'b0, PH_STANDBY, 1'b0, 16'd0, 32'd0));
    send_req(mk_req(REQ_UPDATE, 32'd66000, 1'b0, 1'b0, PH_STANDBY, 1'b0, 16'd0, 32'd0));
  endtask

  task automatic test_random_traffic(int count, int step_max);
    req_t r;
    int pick;
    for (int i = 0; i < count; i++) begin
      calm = (i >= count / 3) && (i < count / 3 + 25);
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 15) == 0) t_ms = t_ms + $urandom;
      else t_ms = t_ms + $urandom_range(0, step_max);
      r.req_type = (pick < 82) ? REQ_UPDATE : (pick < 86) ? REQ_BEGIN :
                   (pick < 93) ? REQ_RESTORE : REQ_FORCE;
      r.now_ms = t_ms;
      r.bottle_full = ($urandom_range(0, 1) == 1);
      r.tank_full = ($urandom_range(0, 9) < 3);
      r.target_phase = $urandom_range(0, 7);
      r.saved_polarity = $urandom_range(0, 1);
      r.saved_elapsed_min = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 8) :
                            $urandom_range(0, 65535);
      r.saved_cycles = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3) :
                       $urandom;
      send_req(r);
      if ($urandom_range(0, 49) == 0) drain_results();
    end
    calm = 1'b0;
  endtask

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    reset_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_default_cycle();
    test_restore_and_force();
    test_cycle_counter_wrap();
    apply_settings($urandom_range(1, 5) * 60000 + $urandom_range(0, 999),
                   $urandom_range(0, 180000), $urandom_range(1, 120000),
                   $urandom_range(1, 4));
    test_random_traffic(150, 40000);
    apply_settings(32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0);
    test_random_traffic(150, 1_000_000);
    apply_settings($urandom, $urandom, $urandom, $urandom_range(0, 255));
    test_random_traffic(150, 2_000_000);
    apply_settings($urandom_range(0, 3000), $urandom_range(0, 3000),
                   $urandom_range(0, 3000), 32'd255);
    test_random_traffic(150, 2000);
    apply_settings($urandom_range(1, 3) * 60000, $urandom_range(1, 2) * 60000,
                   $urandom_range(1, 90000), 32'd1);
    test_random_traffic(150, 30000);
    drain_results();
    $display("Sent %0d requests and checked %0d results over %0d register settings,",
             sent_cnt, checked_cnt, settings_cnt);
    $display("covering every phase, restore, force, wrap and saturation case.");
    if (errors == 0 && pending_status.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
